>>> hdl/pfx_pkg.sv
// shared types, codes and helpers of the postfix expression evaluator
// no dependencies; compiled first
package pfx_pkg;

    localparam int unsigned VAL_W = 32;

    localparam logic [2:0] MODE_DIGIT = 3'd0;
    localparam logic [2:0] MODE_ADD   = 3'd1;
    localparam logic [2:0] MODE_SUB   = 3'd2;
    localparam logic [2:0] MODE_MUL   = 3'd3;
    localparam logic [2:0] MODE_DIV   = 3'd4;
    localparam logic [2:0] MODE_END   = 3'd5;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_UNF  = 3'd1;
    localparam logic [2:0] ST_OVF  = 3'd2;
    localparam logic [2:0] ST_DIVZ = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PUSH,
        CMD_ERR_OVF,
        CMD_ERR_UNF,
        CMD_READ,
        CMD_ADDSUB,
        CMD_MUL,
        CMD_MUL_FIN,
        CMD_DIV_ZERO,
        CMD_DIV_LOAD,
        CMD_DIV_STEP,
        CMD_DIV_FIN,
        CMD_END_TOP,
        CMD_WB,
        CMD_EMIT
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       full;
        logic       lt2;
        logic       empty;
        logic       dig_sat;
        logic       rhs_zero;
        logic       div_last;
        logic       out_free;
    } t_dp_stat;

    typedef struct packed {
        logic                    final_flag;
        logic [2:0]              op_kind;
        logic signed [VAL_W-1:0] left_operand;
        logic signed [VAL_W-1:0] right_operand;
        logic signed [VAL_W-1:0] result_value;
        logic [2:0]              status;
    } t_res_item;

    typedef struct packed {
        logic                    sat;
        logic signed [VAL_W-1:0] value;
    } t_sat;

    function automatic t_sat sat64(input logic signed [63:0] v);
        t_sat r;
        r.sat   = 1'b0;
        r.value = v[VAL_W-1:0];
        if (v > 64'(VAL_MAX)) begin
            r.sat   = 1'b1;
            r.value = VAL_MAX;
        end else if (v < 64'(VAL_MIN)) begin
            r.sat   = 1'b1;
            r.value = VAL_MIN;
        end
        return r;
    endfunction

endpackage

>>> hdl/pfx_tok_if.sv
// token channel: valid/ready with token kind and digit
// depends on pfx_pkg
interface pfx_tok_if import pfx_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [3:0] digit;

    modport source (output valid, output mode, output digit, input ready);
    modport sink   (input valid, input mode, input digit, output ready);
endinterface

>>> hdl/pfx_res_if.sv
// result channel: valid/ready with the operation report fields
// depends on pfx_pkg
interface pfx_res_if import pfx_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    final_flag;
    logic [2:0]              op_kind;
    logic signed [VAL_W-1:0] left_operand;
    logic signed [VAL_W-1:0] right_operand;
    logic signed [VAL_W-1:0] result_value;
    logic [2:0]              status;

    modport source (output valid, output final_flag, output op_kind, output left_operand,
                    output right_operand, output result_value, output status, input ready);
    modport sink   (input valid, input final_flag, input op_kind, input left_operand,
                    input right_operand, input result_value, input status, output ready);
endinterface

>>> hdl/postfix_expression_evaluator.sv
// channel  | dir | handshake   | transaction payload
// i_tok    | in  | valid/ready | mode, digit
// o_res    | out | valid/ready | final_flag, op_kind, left/right_operand, result_value, status
//
// one token at a time; a divide runs through the divider, which takes one quotient bit a cycle
// a result waits in the output register; the next token is taken meanwhile and,
// if it reports, holds in its last step until that register frees
// synchronous active-low reset empties the stack at once; no clearing pass
// top level; depends on pfx_pkg, pfx_tok_if, pfx_res_if, pfx_ctrl, pfx_datapath
module postfix_expression_evaluator import pfx_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfx_tok_if.sink       i_tok,
    pfx_res_if.source     o_res
);
    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_res_item out_item;
    logic      tok_ready;
    logic      out_valid;

    assign i_tok.ready = tok_ready;

    pfx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .i_stat      (stat),
        .o_tok_ready (tok_ready),
        .o_cmd       (cmd)
    );

    pfx_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_tok.mode),
        .i_digit     (i_tok.digit),
        .i_out_ready (o_res.ready),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_out       (out_item)
    );

    assign o_res.valid         = out_valid;
    assign o_res.final_flag    = out_item.final_flag;
    assign o_res.op_kind       = out_item.op_kind;
    assign o_res.left_operand  = out_item.left_operand;
    assign o_res.right_operand = out_item.right_operand;
    assign o_res.result_value  = out_item.result_value;
    assign o_res.status        = out_item.status;
endmodule

>>> hdl/pfx_divider.sv
// radix-2 restoring divider for fixed point: (left * 2^FRAC_BITS) / right, saturated
// one quotient bit per cycle; depends on pfx_pkg
module pfx_divider import pfx_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_step,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic                    o_last,
    output t_sat                    o_result
);
    localparam int unsigned DW = VAL_W + FRAC_BITS;
    localparam int unsigned CW = $clog2(DW);

    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_dvd;
    logic [DW-1:0]    r_quo;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_dvs;
    logic             r_neg;

    logic [VAL_W-1:0] abs_l;
    logic [VAL_W-1:0] abs_r;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   diff;
    logic             ge;
    logic [VAL_W-1:0] neg_q;

    assign abs_l = i_left[VAL_W-1]  ? (~i_left + 32'd1)  : i_left;
    assign abs_r = i_right[VAL_W-1] ? (~i_right + 32'd1) : i_right;
    assign trial = {r_rem, r_dvd[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};
    assign o_last = (r_cnt == '0);
    assign neg_q  = ~r_quo[VAL_W-1:0] + 32'd1;

    always_comb begin
        o_result.sat   = 1'b0;
        o_result.value = r_quo[VAL_W-1:0];
        if (r_neg) begin
            if (r_quo > DW'(32'h8000_0000)) begin
                o_result.sat   = 1'b1;
                o_result.value = VAL_MIN;
            end else begin
                o_result.value = neg_q;
            end
        end else if (r_quo > DW'(32'h7fff_ffff)) begin
            o_result.sat   = 1'b1;
            o_result.value = VAL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW - 1);
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DW'(abs_l) << FRAC_BITS;
            r_dvs <= abs_r;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_left[VAL_W-1] ^ i_right[VAL_W-1];
        end else if (i_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end
endmodule

>>> hdl/pfx_datapath.sv
// datapath: operand stack memory, arithmetic, result record and output register
// depends on pfx_pkg and pfx_divider
module pfx_datapath import pfx_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [2:0] i_mode,
    input  logic [3:0] i_digit,
    input  logic       i_out_ready,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    output t_res_item  o_out
);
    localparam int unsigned AW   = $clog2(STACK_DEPTH);
    localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);

    logic signed [VAL_W-1:0] mem [STACK_DEPTH];

    logic [CNTW-1:0]         r_count;
    logic [2:0]              r_mode;
    logic [3:0]              r_digit;
    logic signed [VAL_W-1:0] r_rd_top;
    logic signed [VAL_W-1:0] r_rd_next;
    logic signed [63:0]      r_prod;
    logic signed [VAL_W-1:0] r_left;
    logic signed [VAL_W-1:0] r_right;
    logic signed [VAL_W-1:0] r_value;
    logic [2:0]              r_status;
    logic                    r_out_valid;
    t_res_item               r_out;

    logic [CNTW-1:0]   cnt_m1;
    logic [CNTW-1:0]   cnt_m2;
    logic [63:0]       push_w;
    t_sat              push_s;
    logic signed [VAL_W:0] addsub_w;
    t_sat              addsub_s;
    logic signed [63:0] prod_sh;
    t_sat              mul_s;
    t_sat              div_s;
    logic              div_last;

    assign cnt_m1   = r_count - 1'b1;
    assign cnt_m2   = r_count - 2'd2;
    assign push_w   = 64'(r_digit) << FRAC_BITS;
    assign push_s   = sat64($signed(push_w));
    assign addsub_w = (r_mode == MODE_SUB) ? (33'(r_rd_next) - 33'(r_rd_top))
                                            : (33'(r_rd_next) + 33'(r_rd_top));
    assign addsub_s = sat64(64'(addsub_w));
    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign mul_s    = sat64(prod_sh);

    pfx_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd == CMD_DIV_LOAD),
        .i_step   (i_cmd == CMD_DIV_STEP),
        .i_left   (r_rd_next),
        .i_right  (r_rd_top),
        .o_last   (div_last),
        .o_result (div_s)
    );

    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.full     = (r_count >= CNTW'(STACK_DEPTH));
        o_stat.lt2      = (r_count < CNTW'(2));
        o_stat.empty    = (r_count == '0);
        o_stat.dig_sat  = push_s.sat;
        o_stat.rhs_zero = (r_rd_top == '0);
        o_stat.div_last = div_last;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_PUSH) begin
            mem[r_count[AW-1:0]] <= push_s.value;
        end else if (i_cmd == CMD_WB) begin
            mem[cnt_m2[AW-1:0]] <= r_value;
        end
        if (i_cmd == CMD_READ) begin
            r_rd_top  <= mem[cnt_m1[AW-1:0]];
            r_rd_next <= mem[cnt_m2[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd)
                CMD_PUSH:    r_count <= r_count + 1'b1;
                CMD_WB:      r_count <= cnt_m1;
                CMD_END_TOP: r_count <= '0;
                default:     r_count <= r_count;
            endcase
            if (i_cmd == CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd) inside
            CMD_LOAD: begin
                r_mode  <= i_mode;
                r_digit <= i_digit;
            end
            CMD_PUSH: begin
                r_left   <= '0;
                r_right  <= '0;
                r_value  <= push_s.value;
                r_status <= push_s.sat ? ST_SAT : ST_OK;
            end
            CMD_ERR_OVF, CMD_ERR_UNF: begin
                r_left   <= '0;
                r_right  <= '0;
                r_value  <= '0;
                r_status <= (i_cmd == CMD_ERR_OVF) ? ST_OVF : ST_UNF;
            end
            CMD_ADDSUB: begin
                r_left   <= r_rd_next;
                r_right  <= r_rd_top;
                r_value  <= addsub_s.value;
                r_status <= addsub_s.sat ? ST_SAT : ST_OK;
            end
            CMD_MUL: begin
                r_left  <= r_rd_next;
                r_right <= r_rd_top;
                r_prod  <= r_rd_next * r_rd_top;
            end
            CMD_MUL_FIN: begin
                r_value  <= mul_s.value;
                r_status <= mul_s.sat ? ST_SAT : ST_OK;
            end
            CMD_DIV_ZERO: begin
                r_left   <= r_rd_next;
                r_right  <= r_rd_top;
                r_value  <= '0;
                r_status <= ST_DIVZ;
            end
            CMD_DIV_LOAD: begin
                r_left  <= r_rd_next;
                r_right <= r_rd_top;
            end
            CMD_DIV_FIN: begin
                r_value  <= div_s.value;
                r_status <= div_s.sat ? ST_SAT : ST_OK;
            end
            CMD_END_TOP: begin
                r_left   <= '0;
                r_right  <= '0;
                r_value  <= r_rd_top;
                r_status <= ST_OK;
            end
            CMD_EMIT: begin
                r_out.final_flag    <= (r_mode == MODE_END);
                r_out.op_kind       <= r_mode;
                r_out.left_operand  <= r_left;
                r_out.right_operand <= r_right;
                r_out.result_value  <= r_value;
                r_out.status        <= r_status;
            end
            default: begin
                r_mode <= r_mode;
            end
        endcase
    end
endmodule

>>> hdl/pfx_ctrl.sv
// controller state machine: sequences one token through the datapath
// depends on pfx_pkg
module pfx_ctrl import pfx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tok_valid,
    input  t_dp_stat i_stat,
    output logic     o_tok_ready,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_MUL_FIN,
        S_DIV_RUN,
        S_DIV_FIN,
        S_WB,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_tok_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.mode) inside
                    MODE_DIGIT: begin
                        if (i_stat.full) begin
                            o_cmd   = CMD_ERR_OVF;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd   = CMD_PUSH;
                            n_state = i_stat.dig_sat ? S_EMIT : S_IDLE;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        o_cmd   = i_stat.lt2 ? CMD_ERR_UNF : CMD_READ;
                        n_state = i_stat.lt2 ? S_EMIT : S_EXEC;
                    end
                    MODE_END: begin
                        o_cmd   = i_stat.empty ? CMD_ERR_UNF : CMD_READ;
                        n_state = i_stat.empty ? S_EMIT : S_EXEC;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EXEC: begin
                unique case (i_stat.mode) inside
                    MODE_ADD, MODE_SUB: begin
                        o_cmd   = CMD_ADDSUB;
                        n_state = S_WB;
                    end
                    MODE_MUL: begin
                        o_cmd   = CMD_MUL;
                        n_state = S_MUL_FIN;
                    end
                    MODE_DIV: begin
                        o_cmd   = i_stat.rhs_zero ? CMD_DIV_ZERO : CMD_DIV_LOAD;
                        n_state = i_stat.rhs_zero ? S_EMIT : S_DIV_RUN;
                    end
                    MODE_END: begin
                        o_cmd   = CMD_END_TOP;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL_FIN: begin
                o_cmd   = CMD_MUL_FIN;
                n_state = S_WB;
            end
            S_DIV_RUN: begin
                o_cmd = CMD_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                o_cmd   = CMD_DIV_FIN;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd   = CMD_WB;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> dv/pfx_checker.sv
// result checker for the postfix expression evaluator: tracks the operand stack from the
// accepted tokens, predicts each report and compares it with the result channel
// depends on pfx_pkg, pfx_tok_if, pfx_res_if
module pfx_checker import pfx_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfx_tok_if          i_tok,
    pfx_res_if          i_res,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [VAL_W-1:0] operand_stack [STACK_DEPTH];
    int unsigned             operand_count = 0;
    t_res_item               owed_reports [$];
    int unsigned             fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic signed [VAL_W-1:0] clamp_q(input longint v, output bit clipped);
        clipped = 1'b1;
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        clipped = 1'b0;
        return VAL_W'(v);
    endfunction

    // updates the stack copy; returns 1 when the token produces a report
    function automatic bit evaluate_token(input logic [2:0] mode, input logic [3:0] digit,
                                          output t_res_item rep);
        logic signed [VAL_W-1:0] lhs;
        logic signed [VAL_W-1:0] rhs;
        logic signed [VAL_W-1:0] val;
        longint                  wide;
        bit                      clipped;
        rep = '0;
        rep.op_kind = mode;
        rep.status  = ST_OK;
        case (mode)
            MODE_DIGIT: begin
                if (operand_count >= STACK_DEPTH) begin
                    rep.status = ST_OVF;
                    return 1'b1;
                end
                val = clamp_q(longint'(digit) <<< FRAC_BITS, clipped);
                operand_stack[operand_count] = val;
                operand_count++;
                if (!clipped)
                    return 1'b0;
                rep.result_value = val;
                rep.status       = ST_SAT;
                return 1'b1;
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (operand_count < 2) begin
                    rep.status = ST_UNF;
                    return 1'b1;
                end
                rhs = operand_stack[operand_count-1];
                lhs = operand_stack[operand_count-2];
                rep.left_operand  = lhs;
                rep.right_operand = rhs;
                case (mode)
                    MODE_ADD: wide = longint'(lhs) + longint'(rhs);
                    MODE_SUB: wide = longint'(lhs) - longint'(rhs);
                    // arithmetic shift floors toward minus infinity
                    MODE_MUL: wide = (longint'(lhs) * longint'(rhs)) >>> FRAC_BITS;
                    default: begin
                        if (rhs == 0) begin
                            rep.status = ST_DIVZ;
                            return 1'b1;
                        end
                        wide = (longint'(lhs) <<< FRAC_BITS) / longint'(rhs);
                    end
                endcase
                val = clamp_q(wide, clipped);
                operand_count--;
                operand_stack[operand_count-1] = val;
                rep.result_value = val;
                rep.status       = clipped ? ST_SAT : ST_OK;
                return 1'b1;
            end
            MODE_END: begin
                rep.final_flag = 1'b1;
                if (operand_count == 0) begin
                    rep.status = ST_UNF;
                    return 1'b1;
                end
                rep.result_value = operand_stack[operand_count-1];
                operand_count = 0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res_item rep;
        t_res_item want;
        if (!i_rst_n) begin
            operand_count = 0;
            owed_reports.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (owed_reports.size() == 0) begin
                    $error("unexpected transaction: op_kind %0d status %0d",
                           i_res.op_kind, i_res.status);
                    fail_count++;
                end else begin
                    want = owed_reports.pop_front();
                    check_field("final_flag", VAL_W'(want.final_flag), VAL_W'(i_res.final_flag));
                    check_field("op_kind", VAL_W'(want.op_kind), VAL_W'(i_res.op_kind));
                    check_field("left_operand", want.left_operand, i_res.left_operand);
                    check_field("right_operand", want.right_operand, i_res.right_operand);
                    check_field("result_value", want.result_value, i_res.result_value);
                    check_field("status", VAL_W'(want.status), VAL_W'(i_res.status));
                end
            end
            if (i_tok.valid && i_tok.ready && evaluate_token(i_tok.mode, i_tok.digit, rep))
                owed_reports.push_back(rep);
        end
        o_pending = owed_reports.size();
    end

endmodule

>>> dv/testbench.sv
// top of the postfix evaluator testbench: clock, reset, token stimulus and result back-pressure
// depends on pfx_pkg, pfx_tok_if, pfx_res_if, pfx_checker and the evaluator itself
module testbench import pfx_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned FRAC         = 16;
    localparam int unsigned ITEM_TARGET  = 1950;
    localparam int unsigned IDLE_PCT     = 22;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned PAUSE_AT     = 1400;
    localparam int unsigned STEADY_FROM  = 700;
    localparam int unsigned STEADY_TO    = 1000;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] digit;
    } t_tok;

    // underflow, divide by zero, growth to both saturation limits, ignored kinds
    localparam t_tok OPENING [26] = '{
        '{MODE_END, 4'd0},   '{MODE_ADD, 4'd0},   '{MODE_DIGIT, 4'd9}, '{MODE_MUL, 4'd0},
        '{MODE_DIGIT, 4'd0}, '{MODE_DIV, 4'd0},   '{MODE_SUB, 4'd0},   '{MODE_DIGIT, 4'd15},
        '{MODE_DIGIT, 4'd15}, '{MODE_MUL, 4'd0},  '{MODE_MUL, 4'd0},   '{MODE_DIGIT, 4'd15},
        '{MODE_MUL, 4'd0},   '{MODE_DIGIT, 4'd15}, '{MODE_MUL, 4'd0},  '{MODE_DIGIT, 4'd0},
        '{MODE_DIGIT, 4'd15}, '{MODE_SUB, 4'd0},  '{MODE_MUL, 4'd0},   '{MODE_DIGIT, 4'd15},
        '{MODE_SUB, 4'd0},   '{MODE_SPARE_LO, 4'd15}, '{MODE_SPARE_HI, 4'd10},
        '{MODE_DIV, 4'd0},   '{MODE_END, 4'd0},   '{MODE_END, 4'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    bit          steady = 1'b0;
    bit          paused = 1'b0;
    int unsigned sent = 0;
    int unsigned quiet = 0;
    int unsigned fail_count;
    int unsigned pending;

    pfx_tok_if tok_if ();
    pfx_res_if res_if ();

    postfix_expression_evaluator #(
        .STACK_DEPTH(DEPTH),
        .FRAC_BITS  (FRAC)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_tok  (tok_if),
        .o_res  (res_if)
    );

    pfx_checker #(
        .STACK_DEPTH(DEPTH),
        .FRAC_BITS  (FRAC)
    ) rpn_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_tok       (tok_if),
        .i_res       (res_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic put_token(input logic [2:0] m, input logic [3:0] d);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            tok_if.valid <= 1'b0;
            @(negedge clk);
        end
        tok_if.valid <= 1'b1;
        tok_if.mode  <= m;
        tok_if.digit <= d;
        do @(posedge clk); while (!tok_if.ready);
        @(negedge clk);
        if (m <= MODE_END)
            sent++;
        steady = (sent >= STEADY_FROM) && (sent < STEADY_TO);
    endtask

    task automatic put_expression(input int unsigned operands);
        int unsigned depth;
        int unsigned left;
        depth = 0;
        left  = operands;
        while (left > 0 || depth > 1) begin
            if (depth < 2 || (left > 0 && $urandom_range(1) == 1)) begin
                put_token(MODE_DIGIT, 4'($urandom_range(15)));
                depth++;
                left--;
            end else begin
                put_token(3'($urandom_range(MODE_DIV, MODE_ADD)), 4'($urandom_range(15)));
                depth--;
            end
        end
        put_token(MODE_END, 4'($urandom_range(15)));
    endtask

    task automatic put_noise();
        if ($urandom_range(3) == 0) begin
            // push storm that can run past the stack limit
            repeat ($urandom_range(20, 14))
                put_token(MODE_DIGIT, 4'($urandom_range(15)));
            put_token(MODE_END, 4'($urandom_range(15)));
        end else begin
            repeat ($urandom_range(8, 1))
                put_token(3'($urandom_range(7)), 4'($urandom_range(15)));
        end
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial begin
        rst_n        = 1'b0;
        tok_if.valid = 1'b0;
        tok_if.mode  = MODE_DIGIT;
        tok_if.digit = 4'd0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (OPENING[k])
            put_token(OPENING[k].mode, OPENING[k].digit);

        while (sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 75)
                put_expression(($urandom_range(9) == 0) ? $urandom_range(15, 6)
                                                        : $urandom_range(5, 1));
            else
                put_noise();
            if (!paused && sent >= PAUSE_AT) begin
                tok_if.valid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
        end

        tok_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
hdl/pfx_pkg.sv
hdl/pfx_tok_if.sv
hdl/pfx_res_if.sv
hdl/pfx_divider.sv
hdl/pfx_datapath.sv
hdl/pfx_ctrl.sv
hdl/postfix_expression_evaluator.sv
dv/pfx_checker.sv
dv/testbench.sv
